// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, request codes and result type of the deque block.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH = 16;

   localparam int OP_W   = 3;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;
   localparam int POS_W  = 5;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [POS_W-1:0]  position_type;

   localparam op_type OP_PUSH_FRONT = 3'd0;
   localparam op_type OP_PUSH_BACK  = 3'd1;
   localparam op_type OP_POP_FRONT  = 3'd2;
   localparam op_type OP_POP_BACK   = 3'd3;
   localparam op_type OP_SEARCH     = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;
   localparam status_type ST_MISS  = 2'd3;

   typedef struct packed {
      position_type position;
      status_type   status;
   } result_type;

endpackage

// File: rtl/deq_mem.sv
// ----------------------------------------------------------------------------
// deq_mem
// Word storage of the ring: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_mem
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  word_type                 wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output word_type                 rd_data
);

   word_type mem [DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: ring pointers, push/pop updates and the search walk over memory.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  op_type                   req_op,
   input  word_type                 req_value,
   output logic                     res_valid,
   input  logic                     res_ready,
   output result_type               res,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output word_type                 wr_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  word_type                 rd_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_HOLD   = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [OW-1:0] chk_ff, chk_in;
   word_type      key_ff, key_in;
   result_type    hold_ff, hold_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic [IW-1:0] front_inc;
   logic [IW-1:0] front_dec;
   logic [IW-1:0] ptr_inc;
   logic [IW:0]   back_sum;
   logic [IW-1:0] back_addr;
   logic [OW-1:0] chk_inc;
   logic          hit;
   logic          last;

   assign full  = (occ_ff == OW'(DEPTH));
   assign empty = (occ_ff == '0);

   // ring index arithmetic, wrap by compare
   assign front_inc = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - 1'b1;
   assign ptr_inc   = (ptr_ff == IW'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign back_sum  = {1'b0, front_ff} + (IW+1)'(occ_ff);
   assign back_addr = (back_sum >= (IW+1)'(DEPTH)) ?
                      IW'(back_sum - (IW+1)'(DEPTH)) : IW'(back_sum);

   assign chk_inc = chk_ff + 1'b1;
   assign hit     = (rd_data == key_ff);
   assign last    = (chk_inc == occ_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      occ_in    = occ_ff;
      ptr_in    = ptr_ff;
      chk_in    = chk_ff;
      key_in    = key_ff;
      hold_in   = hold_ff;
      res_valid = 1'b0;
      res       = '{position: '0, status: ST_OK};
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      wr_data   = req_value;
      rd_en     = 1'b0;
      rd_addr   = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_valid = 1'b1;
               case (req_op)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        res.status = ST_FULL;
                     end else begin
                        front_in = front_dec;
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        occ_in   = occ_ff + 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        res.status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = back_addr;
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        front_in = front_inc;
                        occ_in   = occ_ff - 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        occ_in = occ_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (empty) begin
                        res.status = ST_EMPTY;
                     end else begin
                        // start the walk: first read at the front slot
                        res_valid = 1'b0;
                        rd_en     = 1'b1;
                        rd_addr   = front_ff;
                        ptr_in    = front_inc;
                        chk_in    = '0;
                        key_in    = req_value;
                        state_in  = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
               if (res_valid && !res_ready) begin
                  hold_in  = res;
                  state_in = S_HOLD;
               end
            end
         end
         S_SEARCH: begin
            // compare returned word, fetch the next one in the same cycle
            // unless the walk ends here
            rd_en   = !(hit || last);
            rd_addr = ptr_ff;
            ptr_in  = ptr_inc;
            chk_in  = chk_inc;
            if (hit || last) begin
               res_valid    = 1'b1;
               res.status   = hit ? ST_OK : ST_MISS;
               res.position = hit ? POS_W'(chk_inc) : '0;
               hold_in      = res;
               state_in     = res_ready ? S_IDLE : S_HOLD;
            end
         end
         S_HOLD: begin
            res_valid = 1'b1;
            res       = hold_ff;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      chk_ff  <= chk_in;
      key_ff  <= key_in;
      hold_ff <= hold_in;
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("occupancy beyond depth");

   a_search_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> (occ_ff != '0) && (chk_ff < occ_ff))
      else $error("search walk outside occupied entries");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !full && (req_op == OP_PUSH_FRONT || req_op == OP_PUSH_BACK)
      |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("push did not add an entry");

   a_search_holds_ring: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |=> $stable(front_ff) && $stable(occ_ff))
      else $error("ring changed during search");

endmodule

// File: rtl/deque_with_search_core.sv
// ----------------------------------------------------------------------------
// deque_with_search_core
// Bounded double-ended queue of 32-bit words with a linear search.
// ----------------------------------------------------------------------------
// Each request pushes at the front or back, pops from the front or back, or
// searches for a word, and yields exactly one response (status, position).
// The words live in a ring of DEPTH entries in a single-port-write, registered
// read memory. Pushes and pops finish in the cycle they are accepted; the
// response is registered, and the next request is taken right away even while
// that response waits; the next one then waits in the sequencer, which takes
// no request meanwhile. A search walks the stored words from the front, one
// memory read and one compare per cycle, and takes no request until its
// response is passed on. Only occupied entries are ever read, so the memory
// needs no clearing after reset. Position counts from 1 at the front and is
// kept to its 5-bit field; popped words are simply dropped.
// ----------------------------------------------------------------------------
module deque_with_search_core
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [2:0] operation, [34:3] value, [39:35] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [1:0] status, [6:2] position, [7] zero
);

   localparam int IW = $clog2(DEPTH);

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   word_type      wr_data;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   word_type      rd_data;

   logic          res_valid;
   logic          res_ready;
   result_type    res;

   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff, rsp_data_in;

   deq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   deq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tdata[2:0]),
      .req_value (req_tdata[34:3]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // response register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.position, rsp_data_ff.status};

endmodule

// File: tb/tb_deque_with_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_search_core
// Self-checking bench for the bounded deque with linear search.
// ----------------------------------------------------------------------------
// A mirror of the deque (ring slots, front slot, fill count) predicts status
// and position for every accepted request. Each response is checked against
// the oldest prediction.
//
// Stimulus:
// - A short directed run covers the empty-queue errors, the unused codes,
//   extreme words, fill to full, overflow at both ends, searches that hit
//   in the middle and on the last slot, and a miss.
// - A random run then alternates fill and drain phases. This drives the
//   queue to full and to empty many times. Search keys are drawn mostly
//   from the words held, so first-match ordering is exercised.
// ----------------------------------------------------------------------------

import deq_pkg::*;

class deque_mirror;
   word_type     slots[DEQ_DEPTH];
   int           front;
   int           count;
   result_type   pending_results[$];
   int           errors;
   int           n_done, n_full, n_empty, n_miss, n_found;

   function new();
      front = 0;
      count = 0;
      errors = 0;
      n_done = 0;
      n_full = 0;
      n_empty = 0;
      n_miss = 0;
      n_found = 0;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   // Return a word now held in the queue, or a fresh random one when empty.
   function word_type pick_stored();
      if (count == 0) begin
         return word_type'($urandom);
      end
      return slots[(front + $urandom_range(0, count - 1)) % DEQ_DEPTH];
   endfunction

   // Advance the mirror by one accepted request and queue its response.
   function void note_request(op_type op, word_type value);
      result_type r;
      int         i;
      bit         hit;
      r.status   = ST_OK;
      r.position = '0;
      hit        = 1'b0;
      case (op)
         OP_PUSH_FRONT: begin
            if (count == DEQ_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               front = (front + DEQ_DEPTH - 1) % DEQ_DEPTH;
               slots[front] = value;
               count++;
            end
         end
         OP_PUSH_BACK: begin
            if (count == DEQ_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               slots[(front + count) % DEQ_DEPTH] = value;
               count++;
            end
         end
         OP_POP_FRONT: begin
            if (count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               front = (front + 1) % DEQ_DEPTH;
               count--;
            end
         end
         OP_POP_BACK: begin
            if (count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               count--;
            end
         end
         OP_SEARCH: begin
            if (count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = ST_MISS;
               for (i = 0; i < count && !hit; i++) begin
                  if (slots[(front + i) % DEQ_DEPTH] == value) begin
                     hit        = 1'b1;
                     r.status   = ST_OK;
                     r.position = position_type'(i + 1);
                  end
               end
               if (hit) n_found++;
            end
         end
         default: ;
      endcase
      case (r.status)
         ST_OK:    n_done++;
         ST_FULL:  n_full++;
         ST_EMPTY: n_empty++;
         default:  n_miss++;
      endcase
      pending_results.push_back(r);
   endfunction

   // Compare one accepted response with the oldest prediction.
   function void check_response(logic [7:0] data);
      result_type got;
      result_type want;
      got = result_type'(data[6:0]);
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual status %0d position %0d",
                  $time, got.status, got.position);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
         $display("%0t: status mismatch: expected %0d, actual %0d",
                  $time, want.status, got.status);
         errors++;
      end
      if (got.position !== want.position) begin
         $display("%0t: position mismatch: expected %0d, actual %0d",
                  $time, want.position, got.position);
         errors++;
      end
   endfunction
endclass

module tb_deque_with_search_core;

   localparam int RANDOM_REQUESTS = 2000;
   localparam int QUIET_TAIL      = 300;   // last stretch runs without idling
   localparam int PHASE_LEN       = 64;    // requests per fill or drain phase
   localparam int LONG_HOLD       = 200;   // receiver hold-off, in cycles
   localparam int DRAIN_LIMIT     = 4000;  // cycles allowed for the final drain

   // Codes outside the defined operations; the block must treat them as no-ops.
   localparam op_type OP_UNUSED_FIRST = 3'd5;
   localparam op_type OP_UNUSED_LAST  = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [2:0] operation, [34:3] value, [39:35] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [1:0] status, [6:2] position, [7] zero

   deque_mirror mirror = new();

   bit quiet;                // suppress idling on both sides
   int hold_off_cycles;      // request for one long receiver hold-off

   deque_with_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("Timeout at %0t with %0d responses outstanding", $time, mirror.pending());
      $display("Test completed with failures");
      $finish;
   end

   // Check every accepted response; values sampled here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mirror.check_response(rsp_tdata);
      end
   end

   // Response-side backpressure: random short stalls, plus one long hold-off
   // on request from the main sequence.
   initial begin
      rsp_tready = 1'b0;
      hold_off_cycles = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until the block takes it. An optional idle
   // burst goes ahead of the request; valid stays high between back-to-back
   // requests.
   task automatic send_request(op_type op, word_type value);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, value, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mirror.note_request(op, value);
   endtask

   // Stop offering requests until every predicted response has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
   endtask

   // Draw a word to push: often from a small pool so duplicates occur,
   // sometimes an extreme, otherwise fully random.
   function automatic word_type pick_word();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return word_type'($urandom_range(0, 7));
      if (sel == 4) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return word_type'($urandom);
   endfunction

   initial begin
      int       n;
      int       k;
      int       pick;
      int       waited;
      bit       filling;
      op_type   op;
      word_type value;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      quiet      = 1'b0;
      filling    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: errors on an empty queue and the unused codes.
      send_request(OP_SEARCH, 32'h0000_0000);
      send_request(OP_POP_FRONT, 32'hFFFF_FFFF);
      send_request(OP_POP_BACK, 32'h0000_0000);
      send_request(OP_UNUSED_FIRST, 32'hA5A5_A5A5);
      send_request(OP_UNUSED_LAST, 32'h5A5A_5A5A);

      // Extreme words at both ends: front order becomes 0, max, min, -1.
      send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(OP_PUSH_BACK, 32'h8000_0000);
      send_request(OP_PUSH_FRONT, 32'h0000_0000);
      send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);

      // Fill to full and push at both ends past it.
      for (k = 1; k <= DEQ_DEPTH - 4; k++) begin
         send_request(OP_PUSH_BACK, word_type'(k * 32'h0101_0101));
      end
      send_request(OP_PUSH_FRONT, 32'h1234_5678);
      send_request(OP_PUSH_BACK, 32'h1234_5678);

      // Search hits in the middle and on the last slot, then a miss.
      send_request(OP_SEARCH, 32'h8000_0000);
      send_request(OP_SEARCH, word_type'((DEQ_DEPTH - 4) * 32'h0101_0101));
      send_request(OP_SEARCH, 32'hDEAD_BEEF);
      send_request(OP_POP_FRONT, 32'h0000_0000);
      send_request(OP_POP_BACK, 32'h0000_0000);

      // Random: alternate fill and drain phases so full and empty recur.
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % PHASE_LEN == 0) filling = !filling;
         if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
         // Hold off the receiver for a long stretch; input must stall.
         if (n == 300) hold_off_cycles = LONG_HOLD;
         // Pause the sender until the block has answered everything.
         if (n == RANDOM_REQUESTS / 2) wait_idle();

         pick  = $urandom_range(0, 99);
         value = pick_word();
         if (pick < 4) begin
            op = op_type'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
         end else if (pick < 30) begin
            op = OP_SEARCH;
            if ($urandom_range(0, 9) < 7) value = mirror.pick_stored();
         end else if (pick < (filling ? 80 : 45)) begin
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         end
         send_request(op, value);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding responses, then linger for any stray one.
      waited = 0;
      while (mirror.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DEQ_DEPTH + 8) @(posedge clock);
      if (mirror.pending() != 0) begin
         $display("%0t: %0d responses never arrived: expected %0d more, actual 0",
                  $time, mirror.pending(), mirror.pending());
         mirror.errors++;
      end

      $display("Covered: %0d done/found, %0d overflow, %0d underflow, %0d not found",
               mirror.n_done, mirror.n_full, mirror.n_empty, mirror.n_miss);
      $display("Searches that hit: %0d; mismatches: %0d", mirror.n_found, mirror.errors);
      if (mirror.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/deq_pkg.sv
rtl/deq_mem.sv
rtl/deq_ctrl.sv
rtl/deque_with_search_core.sv
tb/tb_deque_with_search_core.sv
